// ===== rtl/core/signed_decimal_mode_parser_top_macros.svh =====
// Assertion macros for the checker of the decimal mode parser.
`ifndef SIGNED_DECIMAL_MODE_PARSER_TOP_MACROS_SVH
`define SIGNED_DECIMAL_MODE_PARSER_TOP_MACROS_SVH

// The consequent is checked at the same edge as the antecedent.
`define SDMP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sdmp checker: same-cycle property failed");

// The consequent is checked at the next edge after the antecedent.
`define SDMP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sdmp checker: next-cycle property failed");

`endif

// ===== rtl/core/sdmp_pkg.sv =====
// Package with the constants, character codes and types of the decimal mode parser.
package sdmp_pkg;

    localparam int FRAC_DIGITS_DEF = 6;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int CH_W    = 8;
    localparam int INT_W   = 16;
    localparam int CNT_W   = 3;
    localparam int SP_W    = 33;
    localparam int MODE_W  = 8;
    localparam int DIGIT_W = 4;

    localparam logic [INT_W-1:0] INT_MAX = 16'hFFFF;
    localparam int               DEC_BASE = 10;

    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_SKIP  = 8'h53;
    localparam logic [CH_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CH_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        PH_INT,
        PH_FRAC,
        PH_MODE
    } t_phase;

    typedef struct packed {
        logic signed [SP_W-1:0] setpoint;
        logic [MODE_W-1:0]      mode;
        logic                   ended_by;
        logic                   saturated;
    } t_result;

endpackage

// ===== rtl/core/signed_decimal_mode_parser_top.sv =====
// Top level of the decimal mode parser: input register, parser and result register.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------------------
//   char    | in        | i_valid / o_stall   | i_ch
//   result  | out       | o_valid / i_stall   | o_setpoint, o_mode, o_ended_by, o_saturated
//
// One character request is taken every clock cycle while o_stall is low; the parser
// update is a single pass. A completing character is held in the input register, taken
// by the parser, and its result is registered in the result register, which offers it.
// The input register stalls only when it holds a character while the result register is
// full and stalled. Synchronous active-low reset returns the parser to the integer phase.
module signed_decimal_mode_parser_top
    import sdmp_pkg::*;
#(
    parameter int FRAC_DIGITS = FRAC_DIGITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [CH_W-1:0]        i_ch,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic signed [SP_W-1:0] o_setpoint,
    output logic [MODE_W-1:0]      o_mode,
    output logic                   o_ended_by,
    output logic                   o_saturated
);

    logic            r_in_valid;
    logic [CH_W-1:0] r_ch;
    logic            r_out_valid;
    t_result         r_out;

    logic            proc_en;
    logic            done;
    t_result         result;

    assign proc_en = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;

    sdmp_parse #(
        .FRAC_DIGITS (FRAC_DIGITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (proc_en),
        .i_ch     (r_ch),
        .o_done   (done),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_ch <= i_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out <= result;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_setpoint  = r_out.setpoint;
    assign o_mode      = r_out.mode;
    assign o_ended_by  = r_out.ended_by;
    assign o_saturated = r_out.saturated;

endmodule

// ===== rtl/core/sdmp_parse.sv =====
// Parser state and per-character update: builds the value and reports a finished message.
module sdmp_parse
    import sdmp_pkg::*;
#(
    parameter int FRAC_DIGITS = FRAC_DIGITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic [CH_W-1:0] i_ch,
    output logic            o_done,
    output t_result         o_result
);

    localparam int MAG_W  = INT_W + FRAC_BITS;
    localparam int EXT_W  = (MAG_W > SP_W) ? MAG_W : SP_W;
    localparam int PROD_W = FRAC_BITS + DIGIT_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int WIDE_W = INT_W + DIGIT_W;

    localparam longint unsigned TWO_ONE = longint'(1) << (FRAC_BITS + 1);

    // Entry k holds round(2^FRAC_BITS / 10^k); entry 0 is never used.
    localparam logic [FRAC_BITS-1:0] W_TAB [0:7] = '{
        FRAC_BITS'(0),
        FRAC_BITS'((TWO_ONE / DEC_BASE + 1) / 2),
        FRAC_BITS'((TWO_ONE / (DEC_BASE ** 2) + 1) / 2),
        FRAC_BITS'((TWO_ONE / (DEC_BASE ** 3) + 1) / 2),
        FRAC_BITS'((TWO_ONE / (DEC_BASE ** 4) + 1) / 2),
        FRAC_BITS'((TWO_ONE / (DEC_BASE ** 5) + 1) / 2),
        FRAC_BITS'((TWO_ONE / (DEC_BASE ** 6) + 1) / 2),
        FRAC_BITS'((TWO_ONE / (DEC_BASE ** 7) + 1) / 2)
    };

    t_phase               r_phase, n_phase;
    logic                 r_negative, n_negative;
    logic [INT_W-1:0]     r_int_acc, n_int_acc;
    logic [FRAC_BITS-1:0] r_frac_acc, n_frac_acc;
    logic [CNT_W-1:0]     r_frac_count, n_frac_count;
    logic                 r_sat, n_sat;

    logic                 is_digit;
    logic [DIGIT_W-1:0]   dval;
    logic [CH_W-1:0]      ch_off;
    logic [WIDE_W-1:0]    int_wide;
    logic [CNT_W-1:0]     cnt_inc;
    logic [PROD_W-1:0]    frac_prod;
    logic [SUM_W-1:0]     frac_sum;
    logic [MAG_W-1:0]     mag;
    logic [EXT_W-1:0]     mag_ext;
    logic [EXT_W-1:0]     val_ext;

    assign ch_off   = i_ch - CH_ZERO;
    assign is_digit = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign dval     = ch_off[DIGIT_W-1:0];

    // int_acc * 10 as two shifted copies.
    assign int_wide = WIDE_W'({r_int_acc, 3'b000}) + WIDE_W'({r_int_acc, 1'b0})
                    + WIDE_W'(dval);

    assign cnt_inc   = r_frac_count + CNT_W'(1);
    assign frac_prod = PROD_W'(dval) * PROD_W'(W_TAB[cnt_inc]);
    assign frac_sum  = SUM_W'(r_frac_acc) + SUM_W'(frac_prod);

    // The integer part shifted up by FRAC_BITS is simply the concatenation.
    assign mag     = {r_int_acc, r_frac_acc};
    assign mag_ext = EXT_W'(mag);
    assign val_ext = r_negative ? (~mag_ext + EXT_W'(1)) : mag_ext;

    // Result decode.
    always_comb begin
        o_done             = 1'b0;
        o_result.setpoint  = val_ext[SP_W-1:0];
        o_result.mode      = '0;
        o_result.ended_by  = 1'b0;
        o_result.saturated = r_sat;
        if (i_en) begin
            unique case (r_phase)
                PH_MODE: begin
                    o_done        = 1'b1;
                    o_result.mode = ch_off;
                end
                PH_FRAC: begin
                    if (!is_digit && (i_ch != CH_SEMI)) begin
                        o_done            = 1'b1;
                        o_result.ended_by = 1'b1;
                    end
                end
                default: begin
                    if (!is_digit && (i_ch != CH_MINUS) && (i_ch != CH_SKIP)
                        && (i_ch != CH_POINT) && (i_ch != CH_SEMI)) begin
                        o_done            = 1'b1;
                        o_result.ended_by = 1'b1;
                    end
                end
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_phase      = r_phase;
        n_negative   = r_negative;
        n_int_acc    = r_int_acc;
        n_frac_acc   = r_frac_acc;
        n_frac_count = r_frac_count;
        n_sat        = r_sat;
        if (o_done) begin
            n_phase      = PH_INT;
            n_negative   = 1'b0;
            n_int_acc    = '0;
            n_frac_acc   = '0;
            n_frac_count = '0;
            n_sat        = 1'b0;
        end else if (i_en) begin
            unique case (r_phase)
                PH_MODE: begin
                    n_phase = PH_INT;
                end
                PH_FRAC: begin
                    if (is_digit) begin
                        if (r_frac_count < CNT_W'(FRAC_DIGITS)) begin
                            n_frac_count = cnt_inc;
                            if (|frac_sum[SUM_W-1:FRAC_BITS]) begin
                                n_frac_acc = '1;
                            end else begin
                                n_frac_acc = frac_sum[FRAC_BITS-1:0];
                            end
                        end
                    end else if (i_ch == CH_SEMI) begin
                        n_phase = PH_MODE;
                    end
                end
                default: begin
                    if (i_ch == CH_MINUS) begin
                        n_negative = 1'b1;
                    end else if (is_digit) begin
                        if (|int_wide[WIDE_W-1:INT_W]) begin
                            n_int_acc = INT_MAX;
                            n_sat     = 1'b1;
                        end else begin
                            n_int_acc = int_wide[INT_W-1:0];
                        end
                    end else if (i_ch == CH_POINT) begin
                        n_phase = PH_FRAC;
                    end else if (i_ch == CH_SEMI) begin
                        n_phase = PH_MODE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_INT;
            r_negative   <= 1'b0;
            r_int_acc    <= '0;
            r_frac_acc   <= '0;
            r_frac_count <= '0;
            r_sat        <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_negative   <= n_negative;
            r_int_acc    <= n_int_acc;
            r_frac_acc   <= n_frac_acc;
            r_frac_count <= n_frac_count;
            r_sat        <= n_sat;
        end
    end

endmodule

// ===== rtl/core/sdmp_checker.sv =====
// Port-level checker for the decimal mode parser, bound to the top level.
`include "signed_decimal_mode_parser_top_macros.svh"

module sdmp_checker
    import sdmp_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   o_stall,
    input logic                   o_valid,
    input logic                   i_stall,
    input logic signed [SP_W-1:0] o_setpoint,
    input logic [MODE_W-1:0]      o_mode,
    input logic                   o_ended_by,
    input logic                   o_saturated
);

    // A stalled result stays offered.
    `SDMP_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid)

    // A stalled result keeps its payload.
    `SDMP_ASSERT_NEXT(a_out_stable, o_valid && i_stall,
        $stable(o_setpoint) && $stable(o_mode) && $stable(o_ended_by) && $stable(o_saturated))

    // A message cut short by an unexpected character always reports mode zero.
    `SDMP_ASSERT_SAME(a_abort_mode, o_valid && o_ended_by, o_mode == '0)

    // A fresh result needs a character request that the input register took and the parser completed.
    `SDMP_ASSERT_SAME(a_result_cause, $rose(o_valid), $past(i_valid && !o_stall, 2))

endmodule

bind signed_decimal_mode_parser_top sdmp_checker u_sdmp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_setpoint  (o_setpoint),
    .o_mode      (o_mode),
    .o_ended_by  (o_ended_by),
    .o_saturated (o_saturated)
);
